// ===== sv/triangle_plane_clipper_macros.svh =====
`ifndef TRIANGLE_PLANE_CLIPPER_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define TPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpc check failed");

// next-cycle implication
`define TPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpc check failed");

`endif

// ===== sv/tpc_pkg.sv =====
`timescale 1ns / 1ps
package tpc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int NUM_REGS    = 6;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_PX = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PY = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PZ = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NY = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NZ = 3'd5;

  localparam longint NORMAL_Z_RESET = 65536;

  // vertex codes
  localparam logic [1:0] VA = 2'd0;
  localparam logic [1:0] VB = 2'd1;
  localparam logic [1:0] VC = 2'd2;

  // outside masks, bit 0 is vertex A
  localparam logic [2:0] OUT_NONE = 3'b000;
  localparam logic [2:0] OUT_A    = 3'b001;
  localparam logic [2:0] OUT_B    = 3'b010;
  localparam logic [2:0] OUT_C    = 3'b100;
  localparam logic [2:0] IN_A     = 3'b110;
  localparam logic [2:0] IN_B     = 3'b101;
  localparam logic [2:0] IN_C     = 3'b011;
  localparam logic [2:0] OUT_ALL  = 3'b111;

  // crossing c runs from vertex xc towards yc
  typedef struct packed {
    logic [2:0] outm;
    logic [1:0] x0;
    logic [1:0] y0;
    logic [1:0] x1;
    logic [1:0] y1;
  } ctl_t;

  function automatic ctl_t make_ctl(input logic [2:0] outm);
    ctl_t c;
    c.outm = outm;
    case (outm)
      OUT_A: begin c.x0 = VB; c.y0 = VA; c.x1 = VC; c.y1 = VA; end
      OUT_B: begin c.x0 = VC; c.y0 = VB; c.x1 = VA; c.y1 = VB; end
      OUT_C: begin c.x0 = VA; c.y0 = VC; c.x1 = VB; c.y1 = VC; end
      IN_B:  begin c.x0 = VA; c.y0 = VB; c.x1 = VB; c.y1 = VC; end
      IN_C:  begin c.x0 = VB; c.y0 = VC; c.x1 = VA; c.y1 = VC; end
      default: begin c.x0 = VA; c.y0 = VB; c.x1 = VA; c.y1 = VC; end
    endcase
    return c;
  endfunction

  function automatic logic [1:0] result_count(input logic [2:0] outm);
    logic [1:0] n;
    case (outm)
      OUT_NONE:               n = 2'd1;
      OUT_ALL:                n = 2'd0;
      OUT_A, OUT_B, OUT_C:    n = 2'd2;
      default:                n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/tpc_dist.sv =====
`timescale 1ns / 1ps
module tpc_dist #(
  parameter int W = tpc_pkg::COORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  logic signed [W-1:0]     in_vtx [9],
  input  logic signed [W-1:0]     plane_q [3],
  input  logic signed [W-1:0]     plane_n [3],
  output logic                    out_v,
  output logic signed [W-1:0]     out_vtx [9],
  output logic signed [2*W+2:0]   out_d [3],
  output logic [2:0]              out_outm
);

  localparam int DW = 2 * W + 3;
  localparam int PW = 2 * W + 1;

  logic                  v0_r, v1_r, v2_r;
  logic signed [W-1:0]   vtx0_r [9];
  logic signed [W-1:0]   vtx1_r [9];
  logic signed [W-1:0]   vtx2_r [9];
  logic signed [W:0]     diff_r [9];
  logic signed [PW-1:0]  prod_r [9];
  logic signed [DW-1:0]  d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          vtx0_r[3*j+k] <= in_vtx[3*j+k];
          diff_r[3*j+k] <= (W+1)'(in_vtx[3*j+k]) - (W+1)'(plane_q[k]);
          vtx1_r[3*j+k] <= vtx0_r[3*j+k];
          prod_r[3*j+k] <= plane_n[k] * diff_r[3*j+k];
          vtx2_r[3*j+k] <= vtx1_r[3*j+k];
        end
        d_r[j] <= DW'(prod_r[3*j]) + DW'(prod_r[3*j+1]) + DW'(prod_r[3*j+2]);
      end
    end
  end

  assign out_v    = v2_r;
  assign out_vtx  = vtx2_r;
  assign out_d    = d_r;
  // d = 0 counts as inside
  assign out_outm = {d_r[2][DW-1], d_r[1][DW-1], d_r[0][DW-1]};

endmodule

// ===== sv/tpc_edge.sv =====
`timescale 1ns / 1ps
module tpc_edge #(
  parameter int W = tpc_pkg::COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic signed [W-1:0]    in_vtx [9],
  input  logic signed [2*W+2:0]  in_d [3],
  input  logic [2:0]             in_outm,
  output logic                   out_v,
  output tpc_pkg::ctl_t          out_ctl,
  output logic signed [W-1:0]    out_vtx [9],
  output logic [3*W+2:0]         out_num [6],
  output logic [2*W+2:0]         out_den [2],
  output logic [5:0]             out_neg
);

  localparam int DW = 2 * W + 3;
  localparam int NW = W + DW;
  localparam int HW = DW - 2 * W;

  function automatic logic signed [W-1:0] pick_v(input logic [1:0] s,
      input logic signed [W-1:0] a, input logic signed [W-1:0] b,
      input logic signed [W-1:0] c);
    case (s)
      tpc_pkg::VA: return a;
      tpc_pkg::VB: return b;
      default:     return c;
    endcase
  endfunction

  function automatic logic signed [DW-1:0] pick_d(input logic [1:0] s,
      input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
      input logic signed [DW-1:0] c);
    case (s)
      tpc_pkg::VA: return a;
      tpc_pkg::VB: return b;
      default:     return c;
    endcase
  endfunction

  tpc_pkg::ctl_t       ctl_nxt;
  logic [W-1:0]        mag_nxt [6];
  logic [5:0]          neg_nxt;
  logic [DW-1:0]       num_nxt [2];
  logic [DW-1:0]       den_nxt [2];

  logic                v3_r, v4_r, v5_r;
  tpc_pkg::ctl_t       ctl3_r, ctl4_r, ctl5_r;
  logic signed [W-1:0] vtx3_r [9];
  logic signed [W-1:0] vtx4_r [9];
  logic signed [W-1:0] vtx5_r [9];
  logic [W-1:0]        mag3_r [6];
  logic [5:0]          neg3_r, neg4_r, neg5_r;
  logic [DW-1:0]       num3_r [2];
  logic [DW-1:0]       den3_r [2];
  logic [DW-1:0]       den4_r [2];
  logic [DW-1:0]       den5_r [2];
  logic [2*W-1:0]      pp0_r [6];
  logic [2*W-1:0]      pp1_r [6];
  logic [W+HW-1:0]     pp2_r [6];
  logic [NW-1:0]       n5_r [6];

  always_comb begin
    logic [1:0]           xs, ys;
    logic signed [DW-1:0] dx, dy;
    logic signed [DW:0]   dd;
    logic signed [W:0]    e;
    ctl_nxt = tpc_pkg::make_ctl(in_outm);
    for (int c = 0; c < 2; c++) begin
      xs = (c == 0) ? ctl_nxt.x0 : ctl_nxt.x1;
      ys = (c == 0) ? ctl_nxt.y0 : ctl_nxt.y1;
      dx = pick_d(xs, in_d[0], in_d[1], in_d[2]);
      dy = pick_d(ys, in_d[0], in_d[1], in_d[2]);
      dd = (DW+1)'(dx) - (DW+1)'(dy);
      num_nxt[c] = dx[DW-1] ? DW'(-dx) : DW'(dx);
      den_nxt[c] = dd[DW] ? DW'(-dd) : DW'(dd);
      for (int k = 0; k < 3; k++) begin
        e = (W+1)'(pick_v(ys, in_vtx[k], in_vtx[3+k], in_vtx[6+k]))
          - (W+1)'(pick_v(xs, in_vtx[k], in_vtx[3+k], in_vtx[6+k]));
        neg_nxt[3*c+k] = e[W];
        mag_nxt[3*c+k] = e[W] ? W'(-e) : W'(e);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_v;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3_r <= ctl_nxt;
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      neg3_r <= neg_nxt;
      neg4_r <= neg3_r;
      neg5_r <= neg4_r;
      for (int i = 0; i < 9; i++) begin
        vtx3_r[i] <= in_vtx[i];
        vtx4_r[i] <= vtx3_r[i];
        vtx5_r[i] <= vtx4_r[i];
      end
      for (int c = 0; c < 2; c++) begin
        num3_r[c] <= num_nxt[c];
        den3_r[c] <= den_nxt[c];
        den4_r[c] <= den3_r[c];
        den5_r[c] <= den4_r[c];
        for (int k = 0; k < 3; k++) begin
          mag3_r[3*c+k] <= mag_nxt[3*c+k];
          // |edge| * |dX| in three partial products
          pp0_r[3*c+k] <= (2*W)'(mag3_r[3*c+k]) * (2*W)'(num3_r[c][W-1:0]);
          pp1_r[3*c+k] <= (2*W)'(mag3_r[3*c+k]) * (2*W)'(num3_r[c][2*W-1:W]);
          pp2_r[3*c+k] <= (W+HW)'(mag3_r[3*c+k]) * (W+HW)'(num3_r[c][DW-1:2*W]);
          n5_r[3*c+k]  <= NW'(pp0_r[3*c+k]) + (NW'(pp1_r[3*c+k]) << W)
                        + (NW'(pp2_r[3*c+k]) << (2*W));
        end
      end
    end
  end

  assign out_v   = v5_r;
  assign out_ctl = ctl5_r;
  assign out_vtx = vtx5_r;
  assign out_num = n5_r;
  assign out_den = den5_r;
  assign out_neg = neg5_r;

endmodule

// ===== sv/tpc_div.sv =====
`timescale 1ns / 1ps
module tpc_div #(
  parameter int W = tpc_pkg::COORD_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  tpc_pkg::ctl_t          in_ctl,
  input  logic signed [W-1:0]    in_vtx [9],
  input  logic [3*W+2:0]         in_num [6],
  input  logic [2*W+2:0]         in_den [2],
  input  logic [5:0]             in_neg,
  output logic                   out_v,
  output tpc_pkg::ctl_t          out_ctl,
  output logic signed [W-1:0]    out_vtx [9],
  output logic [W-1:0]           out_q [6],
  output logic [5:0]             out_neg
);

  localparam int DW = 2 * W + 3;
  localparam int NW = W + DW;

  // one quotient bit per stage; the quotient never exceeds |edge|
  logic [W-1:0]        v_r;
  tpc_pkg::ctl_t       ctl_r [W];
  logic signed [W-1:0] vtx_r [W][9];
  logic [DW-1:0]       rem_r [W][6];
  logic [W-1:0]        nl_r  [W][6];
  logic [DW-1:0]       den_r [W][2];
  logic [5:0]          neg_r [W];

  for (genvar s = 0; s < W; s++) begin : g_stg
    logic                v_i;
    tpc_pkg::ctl_t       ctl_i;
    logic signed [W-1:0] vtx_i [9];
    logic [DW-1:0]       rem_i [6];
    logic [W-1:0]        nl_i  [6];
    logic [DW-1:0]       den_i [2];
    logic [5:0]          neg_i;
    logic [DW-1:0]       rem_nxt [6];
    logic [W-1:0]        nl_nxt  [6];

    if (s == 0) begin : g_head
      always_comb begin
        v_i   = in_v;
        ctl_i = in_ctl;
        vtx_i = in_vtx;
        den_i = in_den;
        neg_i = in_neg;
        for (int l = 0; l < 6; l++) begin
          rem_i[l] = in_num[l][NW-1:W];
          nl_i[l]  = in_num[l][W-1:0];
        end
      end
    end else begin : g_body
      always_comb begin
        v_i   = v_r[s-1];
        ctl_i = ctl_r[s-1];
        vtx_i = vtx_r[s-1];
        den_i = den_r[s-1];
        neg_i = neg_r[s-1];
        rem_i = rem_r[s-1];
        nl_i  = nl_r[s-1];
      end
    end

    always_comb begin
      logic [DW:0] t;
      logic [DW:0] dn;
      logic        q;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 3; k++) begin
          t  = {rem_i[3*c+k], nl_i[3*c+k][W-1]};
          dn = {1'b0, den_i[c]};
          q  = (t >= dn);
          if (q) t = t - dn;
          rem_nxt[3*c+k] = t[DW-1:0];
          nl_nxt[3*c+k]  = {nl_i[3*c+k][W-2:0], q};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en) v_r[s] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[s] <= ctl_i;
        vtx_r[s] <= vtx_i;
        den_r[s] <= den_i;
        neg_r[s] <= neg_i;
        rem_r[s] <= rem_nxt;
        nl_r[s]  <= nl_nxt;
      end
    end
  end

  assign out_v   = v_r[W-1];
  assign out_ctl = ctl_r[W-1];
  assign out_vtx = vtx_r[W-1];
  assign out_q   = nl_r[W-1];
  assign out_neg = neg_r[W-1];

endmodule

// ===== sv/triangle_plane_clipper.sv =====
// Throughput: one triangle word per cycle while out_ready is high; the pipeline takes a
// new triangle every cycle unless the output buffer is busy, and one that splits in two
// holds intake at the output until its second word is taken.
// The restoring divider, one quotient bit per stage, sets the pipeline depth.
// Reset (rst_n low, synchronous) empties the pipeline and sets the plane registers
// to point 0 and normal (0, 0, 1.0).
`timescale 1ns / 1ps
`include "triangle_plane_clipper_macros.svh"
module triangle_plane_clipper #(
  parameter int COORD_WIDTH = tpc_pkg::COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tpc_pkg::REG_IDX_W-1:0]   cfg_idx,
  input  logic [COORD_WIDTH-1:0]          cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_ax,
  input  logic signed [COORD_WIDTH-1:0]   in_ay,
  input  logic signed [COORD_WIDTH-1:0]   in_az,
  input  logic signed [COORD_WIDTH-1:0]   in_bx,
  input  logic signed [COORD_WIDTH-1:0]   in_by,
  input  logic signed [COORD_WIDTH-1:0]   in_bz,
  input  logic signed [COORD_WIDTH-1:0]   in_cx,
  input  logic signed [COORD_WIDTH-1:0]   in_cy,
  input  logic signed [COORD_WIDTH-1:0]   in_cz,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [COORD_WIDTH-1:0]   out_ax,
  output logic signed [COORD_WIDTH-1:0]   out_ay,
  output logic signed [COORD_WIDTH-1:0]   out_az,
  output logic signed [COORD_WIDTH-1:0]   out_bx,
  output logic signed [COORD_WIDTH-1:0]   out_by,
  output logic signed [COORD_WIDTH-1:0]   out_bz,
  output logic signed [COORD_WIDTH-1:0]   out_cx,
  output logic signed [COORD_WIDTH-1:0]   out_cy,
  output logic signed [COORD_WIDTH-1:0]   out_cz,
  output logic                            out_last_triangle
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 3;
  localparam int NW = W + DW;

  function automatic logic signed [W-1:0] pick_v(input logic [1:0] s,
      input logic signed [W-1:0] a, input logic signed [W-1:0] b,
      input logic signed [W-1:0] c);
    case (s)
      tpc_pkg::VA: return a;
      tpc_pkg::VB: return b;
      default:     return c;
    endcase
  endfunction

  logic signed [W-1:0] pq_r [3];
  logic signed [W-1:0] pn_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pq_r[0] <= '0;
      pq_r[1] <= '0;
      pq_r[2] <= '0;
      pn_r[0] <= '0;
      pn_r[1] <= '0;
      pn_r[2] <= W'(tpc_pkg::NORMAL_Z_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        tpc_pkg::REG_PX: pq_r[0] <= cfg_data;
        tpc_pkg::REG_PY: pq_r[1] <= cfg_data;
        tpc_pkg::REG_PZ: pq_r[2] <= cfg_data;
        tpc_pkg::REG_NX: pn_r[0] <= cfg_data;
        tpc_pkg::REG_NY: pn_r[1] <= cfg_data;
        tpc_pkg::REG_NZ: pn_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                en;
  logic signed [W-1:0] in_vtx [9];

  assign in_vtx[0] = in_ax;
  assign in_vtx[1] = in_ay;
  assign in_vtx[2] = in_az;
  assign in_vtx[3] = in_bx;
  assign in_vtx[4] = in_by;
  assign in_vtx[5] = in_bz;
  assign in_vtx[6] = in_cx;
  assign in_vtx[7] = in_cy;
  assign in_vtx[8] = in_cz;

  logic                dist_v;
  logic signed [W-1:0] dist_vtx [9];
  logic signed [DW-1:0] dist_d [3];
  logic [2:0]          dist_outm;

  tpc_dist #(.W(W)) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .in_vtx   (in_vtx),
    .plane_q  (pq_r),
    .plane_n  (pn_r),
    .out_v    (dist_v),
    .out_vtx  (dist_vtx),
    .out_d    (dist_d),
    .out_outm (dist_outm)
  );

  logic                edge_v;
  tpc_pkg::ctl_t       edge_ctl;
  logic signed [W-1:0] edge_vtx [9];
  logic [NW-1:0]       edge_num [6];
  logic [DW-1:0]       edge_den [2];
  logic [5:0]          edge_neg;

  tpc_edge #(.W(W)) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (dist_v),
    .in_vtx  (dist_vtx),
    .in_d    (dist_d),
    .in_outm (dist_outm),
    .out_v   (edge_v),
    .out_ctl (edge_ctl),
    .out_vtx (edge_vtx),
    .out_num (edge_num),
    .out_den (edge_den),
    .out_neg (edge_neg)
  );

  logic                fin_v;
  tpc_pkg::ctl_t       fin_ctl;
  logic signed [W-1:0] fin_vtx [9];
  logic [W-1:0]        fin_q [6];
  logic [5:0]          fin_neg;

  tpc_div #(.W(W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (edge_v),
    .in_ctl  (edge_ctl),
    .in_vtx  (edge_vtx),
    .in_num  (edge_num),
    .in_den  (edge_den),
    .in_neg  (edge_neg),
    .out_v   (fin_v),
    .out_ctl (fin_ctl),
    .out_vtx (fin_vtx),
    .out_q   (fin_q),
    .out_neg (fin_neg)
  );

  // crossing points and triangle assembly
  logic signed [W-1:0] t0_nxt [9];
  logic signed [W-1:0] t1_nxt [9];
  logic [1:0]          fin_cnt;

  always_comb begin
    logic signed [W-1:0] cp [2][3];
    logic signed [W-1:0] x;
    logic signed [W:0]   off;
    logic signed [W:0]   sum;
    logic [1:0]          xs;
    for (int c = 0; c < 2; c++) begin
      xs = (c == 0) ? fin_ctl.x0 : fin_ctl.x1;
      for (int k = 0; k < 3; k++) begin
        x   = pick_v(xs, fin_vtx[k], fin_vtx[3+k], fin_vtx[6+k]);
        off = fin_neg[3*c+k] ? -(W+1)'(fin_q[3*c+k]) : (W+1)'(fin_q[3*c+k]);
        sum = (W+1)'(x) + off;
        cp[c][k] = sum[W-1:0];
      end
    end
    fin_cnt = tpc_pkg::result_count(fin_ctl.outm);
    for (int k = 0; k < 3; k++) begin
      t0_nxt[k]   = fin_vtx[k];
      t0_nxt[3+k] = fin_vtx[3+k];
      t0_nxt[6+k] = fin_vtx[6+k];
      t1_nxt[k]   = cp[0][k];
      t1_nxt[3+k] = fin_vtx[6+k];
      t1_nxt[6+k] = cp[1][k];
      case (fin_ctl.outm)
        tpc_pkg::OUT_A: begin
          t0_nxt[k] = cp[0][k];
        end
        tpc_pkg::OUT_B: begin
          t0_nxt[k]   = cp[0][k];
          t0_nxt[3+k] = fin_vtx[6+k];
          t0_nxt[6+k] = fin_vtx[k];
          t1_nxt[3+k] = fin_vtx[k];
        end
        tpc_pkg::OUT_C: begin
          t0_nxt[k]   = cp[0][k];
          t0_nxt[3+k] = fin_vtx[k];
          t0_nxt[6+k] = fin_vtx[3+k];
          t1_nxt[3+k] = fin_vtx[3+k];
        end
        tpc_pkg::IN_A: begin
          t0_nxt[3+k] = cp[0][k];
          t0_nxt[6+k] = cp[1][k];
        end
        tpc_pkg::IN_B: begin
          t0_nxt[k]   = cp[0][k];
          t0_nxt[6+k] = cp[1][k];
        end
        tpc_pkg::IN_C: begin
          t0_nxt[k]   = cp[1][k];
          t0_nxt[3+k] = cp[0][k];
        end
        default: ;
      endcase
    end
  end

  // output buffer: up to two words per triangle
  logic                obuf_v_r;
  logic                sel_r;
  logic                two_r;
  logic signed [W-1:0] t0_r [9];
  logic signed [W-1:0] t1_r [9];
  logic                free;
  logic                load;

  assign out_valid         = obuf_v_r;
  assign out_last_triangle = ~two_r | sel_r;
  assign free = ~obuf_v_r | (out_ready & out_last_triangle);
  assign en   = ~fin_v | (fin_cnt == 2'd0) | free;
  assign load = fin_v & en & (fin_cnt != 2'd0);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_v_r <= 1'b0;
      sel_r    <= 1'b0;
      two_r    <= 1'b0;
    end else if (load) begin
      obuf_v_r <= 1'b1;
      sel_r    <= 1'b0;
      two_r    <= (fin_cnt == 2'd2);
    end else if (obuf_v_r && out_ready) begin
      if (out_last_triangle) obuf_v_r <= 1'b0;
      else sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
    end
  end

  assign out_ax = sel_r ? t1_r[0] : t0_r[0];
  assign out_ay = sel_r ? t1_r[1] : t0_r[1];
  assign out_az = sel_r ? t1_r[2] : t0_r[2];
  assign out_bx = sel_r ? t1_r[3] : t0_r[3];
  assign out_by = sel_r ? t1_r[4] : t0_r[4];
  assign out_bz = sel_r ? t1_r[5] : t0_r[5];
  assign out_cx = sel_r ? t1_r[6] : t0_r[6];
  assign out_cy = sel_r ? t1_r[7] : t0_r[7];
  assign out_cz = sel_r ? t1_r[8] : t0_r[8];

  `TPC_ASSERT_NEXT(a_second_word_follows, out_valid && out_ready && !out_last_triangle,
                   out_valid && out_last_triangle)
  `TPC_ASSERT_NOW(a_stall_only_when_full, !in_ready, fin_v && obuf_v_r)
  `TPC_ASSERT_NEXT(a_split_loads_pair, load && fin_cnt == 2'd2,
                   out_valid && !out_last_triangle)

endmodule
